FILE: src/vfv_pkg.sv
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants of the voxel face visibility unit: field widths,
// command and register codes, the sequencer state type and the face table.
// ----------------------------------------------------------------------------
package vfv_pkg;

    localparam int COORD_W  = 5;
    localparam int GID_W    = 16;
    localparam int MASK_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GRID_W   = 6;
    localparam int EDGE_W   = 7;    // holds an edge length up to 127
    localparam int STEP_W   = 3;

    // Commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLODED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS    = 2'd2;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Face order of the mask: -x, +y, +x, -y, +z, -z.
    function automatic logic [1:0] face_axis(input logic [STEP_W-1:0] face);
        logic [1:0] axis;
        case (face)
            3'd0, 3'd2: axis = AXIS_X;
            3'd1, 3'd3: axis = AXIS_Y;
            default:    axis = AXIS_Z;
        endcase
        return axis;
    endfunction

    function automatic logic face_up(input logic [STEP_W-1:0] face);
        logic up;
        case (face)
            3'd1, 3'd2, 3'd4: up = 1'b1;
            default:          up = 1'b0;
        endcase
        return up;
    endfunction

endpackage

FILE: src/vfv_if.sv
// ----------------------------------------------------------------------------
// vfv interfaces
// Valid/ready channels of the voxel face visibility unit: command input,
// result output and configuration writes.
// ----------------------------------------------------------------------------
interface vfv_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [vfv_pkg::COORD_W-1:0] pos_x;
    logic [vfv_pkg::COORD_W-1:0] pos_y;
    logic [vfv_pkg::COORD_W-1:0] pos_z;
    logic [vfv_pkg::GID_W-1:0]   grain_id;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, grain_id, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, grain_id, output ready);
endinterface

interface vfv_out_if;
    logic                       valid;
    logic                       ready;
    logic [vfv_pkg::MASK_W-1:0] face_mask;
    logic                       skip;
    logic [vfv_pkg::GID_W-1:0]  cell_id;

    modport source (output valid, face_mask, skip, cell_id, input ready);
    modport sink   (input valid, face_mask, skip, cell_id, output ready);
endinterface

interface vfv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vfv_pkg::CFG_IDX_W-1:0]  index;
    logic [vfv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/voxel_face_visibility_unit.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_unit
// Six-neighbour hidden-face culling over a cubic grid of grain identifiers.
// ----------------------------------------------------------------------------
// The block holds a grid of grain ids in one single-ported memory. Each input
// transaction on i_in is either a write (store grain_id at a coordinate) or a
// query (return the visible-face mask of one voxel). Every input transaction
// gives exactly one output transaction on o_out. Registers are written through
// i_cfg, which is always ready; write them only while the block is idle.
//
// A write is stored in its accept cycle; its echo goes through the staged
// result register into the output register, and the next item is taken once
// the sequencer is back in idle. A query reads the centre voxel in its accept
// cycle and once more as the sequencer starts, then the six neighbours (-x,
// +y, +x, -y, +z, -z), one per cycle, using a single shared step-and-bound
// unit for the neighbour coordinates; the last face ends the mask in the
// staged result register, which loads the output register before the next
// item is taken. An outside query goes straight to a skipped, zero-id result.
//
// If the receiver stalls, a result waits in the output register and the next
// item is still accepted; the result after it waits in the sequencer, with
// i_in.ready low, until the output register is free. Reset returns the
// sequencer to idle, empties the output register and sets grid_size 1,
// exploded_mode 0, num_colors 0; the grid memory is not cleared.
// ----------------------------------------------------------------------------
module voxel_face_visibility_unit #(
    parameter int GRID_DIM_MAX = 32,
    parameter int ID_BITS      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfv_in_if.sink    i_in,
    vfv_out_if.source o_out,
    vfv_cfg_if.sink   i_cfg
);
    import vfv_pkg::*;

    localparam int DEPTH = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [EDGE_W-1:0] GDIM = EDGE_W'(GRID_DIM_MAX);

    // Configuration registers.
    logic [GRID_W-1:0]     r_grid_size;
    logic                  r_exploded;
    logic [CFG_DATA_W-1:0] r_num_colors;

    // Sequencer.
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [COORD_W-1:0]  r_x, r_y, r_z;
    logic                r_rd_inb;
    logic [ID_BITS-1:0]  r_centre, n_centre;
    logic [MASK_W-1:0]   r_mask, n_mask;

    // Staged result and output register.
    logic [MASK_W-1:0]   r_res_mask, n_res_mask;
    logic                r_res_skip, n_res_skip;
    logic [GID_W-1:0]    r_res_id, n_res_id;
    logic                r_out_valid, n_out_valid;
    logic [MASK_W-1:0]   r_out_mask;
    logic                r_out_skip;
    logic [GID_W-1:0]    r_out_id;

    // Grid memory.
    logic [ID_BITS-1:0]  r_mem [DEPTH];
    logic [ID_BITS-1:0]  r_rd_data;

    logic [EDGE_W-1:0]   w_n;
    logic                w_inside;
    logic                w_accept;
    logic [31:0]         w_gid_ext;
    logic [ID_BITS-1:0]  w_gid;

    logic [STEP_W-1:0]   w_face;
    logic [1:0]          w_axis;
    logic                w_up;
    logic [EDGE_W-1:0]   w_c, w_sum;
    logic                w_inb;
    logic [EDGE_W-1:0]   w_ax, w_ay, w_az;
    logic [AW-1:0]       w_addr;
    logic                w_we;
    logic                w_hidden;
    logic [STEP_W-1:0]   w_bit;
    logic                w_load_out;

    // Effective edge is min(grid_size, GRID_DIM_MAX).
    assign w_n = ({1'b0, r_grid_size} < GDIM) ? {1'b0, r_grid_size} : GDIM;

    assign w_inside = ({2'b00, i_in.pos_x} < w_n) && ({2'b00, i_in.pos_y} < w_n)
                   && ({2'b00, i_in.pos_z} < w_n);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_gid_ext = 32'(i_in.grain_id);
    assign w_gid     = w_gid_ext[ID_BITS-1:0];

    // Shared neighbour unit: one axis is stepped by one and bound-checked.
    // Step 0 is the centre voxel itself; steps 1 to 6 are the faces in order.
    assign w_face = STEP_W'(r_step - 3'd1);
    assign w_axis = face_axis(w_face);
    assign w_up   = face_up(w_face);

    always_comb begin
        case (w_axis)
            AXIS_X:  w_c = EDGE_W'(r_x);
            AXIS_Y:  w_c = EDGE_W'(r_y);
            default: w_c = EDGE_W'(r_z);
        endcase
        w_sum = w_up ? EDGE_W'(w_c + 1'b1) : EDGE_W'(w_c - 1'b1);
        w_inb = (r_step == '0) || (w_up ? (w_sum < w_n) : (w_c != '0));

        if (r_state == S_IDLE) begin
            w_ax = EDGE_W'(i_in.pos_x);
            w_ay = EDGE_W'(i_in.pos_y);
            w_az = EDGE_W'(i_in.pos_z);
        end else begin
            w_ax = EDGE_W'(r_x);
            w_ay = EDGE_W'(r_y);
            w_az = EDGE_W'(r_z);
            if (r_step != '0) begin
                case (w_axis)
                    AXIS_X:  w_ax = w_sum;
                    AXIS_Y:  w_ay = w_sum;
                    default: w_az = w_sum;
                endcase
            end
        end
    end

    assign w_addr = AW'(int'(w_ax) + int'(w_ay) * GRID_DIM_MAX
                        + int'(w_az) * GRID_DIM_MAX * GRID_DIM_MAX);

    assign w_we = w_accept && (i_in.cmd == CMD_WRITE) && w_inside;

    // One port: a write in the accept cycle of a write, and a read every cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_gid;
        end
        r_rd_data <= r_mem[w_addr];
    end

    // Face test on the data that arrived for the read issued last cycle.
    assign w_hidden = r_rd_inb && (r_exploded ? (r_rd_data == r_centre)
                                              : (r_rd_data != '0));
    assign w_bit    = STEP_W'(r_step - 3'd2);

    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_centre    = r_centre;
        n_mask      = r_mask;
        n_res_mask  = r_res_mask;
        n_res_skip  = r_res_skip;
        n_res_id    = r_res_id;
        n_out_valid = r_out_valid;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_step = '0;
                    n_mask = '0;
                    if (i_in.cmd == CMD_WRITE) begin
                        n_res_mask = '0;
                        n_res_skip = 1'b0;
                        n_res_id   = GID_W'(32'(w_gid));
                        n_state    = S_DONE;
                    end else if (!w_inside) begin
                        n_res_mask = '0;
                        n_res_skip = 1'b1;
                        n_res_id   = '0;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_step = STEP_W'(r_step + 3'd1);
                if (r_step == 3'd1) begin
                    n_centre = r_rd_data;
                end else if (r_step != '0) begin
                    n_mask[w_bit] = !w_hidden;
                end
                if (r_step == 3'd7) begin
                    if (r_centre == '0) begin
                        n_res_mask = '0;
                        n_res_skip = 1'b1;
                        n_res_id   = '0;
                    end else begin
                        n_res_mask = n_mask;
                        n_res_skip = (n_mask == '0)
                                  || (32'(r_centre) > 32'(r_num_colors));
                        n_res_id   = GID_W'(32'(r_centre));
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_grid_size  <= GRID_W'(1);
            r_exploded   <= 1'b0;
            r_num_colors <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_GRID_SIZE:     r_grid_size  <= i_cfg.data[GRID_W-1:0];
                    CFG_EXPLODED_MODE: r_exploded   <= i_cfg.data[0];
                    CFG_NUM_COLORS:    r_num_colors <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_centre   <= n_centre;
        r_mask     <= n_mask;
        r_res_mask <= n_res_mask;
        r_res_skip <= n_res_skip;
        r_res_id   <= n_res_id;
        r_rd_inb   <= w_inb;
        if (w_accept) begin
            r_x <= i_in.pos_x;
            r_y <= i_in.pos_y;
            r_z <= i_in.pos_z;
        end
        if (w_load_out) begin
            r_out_mask <= r_res_mask;
            r_out_skip <= r_res_skip;
            r_out_id   <= r_res_id;
        end
    end

    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.face_mask = r_out_mask;
    assign o_out.skip      = r_out_skip;
    assign o_out.cell_id   = r_out_id;

endmodule

FILE: src/vfv_checker.sv
// ----------------------------------------------------------------------------
// vfv_checker
// Port-level checks of the voxel face visibility unit, bound to the top level.
// ----------------------------------------------------------------------------
module vfv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_cmd,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [vfv_pkg::MASK_W-1:0]  i_face_mask,
    input logic                        i_skip,
    input logic [vfv_pkg::GID_W-1:0]   i_cell_id
);
    import vfv_pkg::*;

    // A held result does not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_face_mask) && $stable(i_skip) && $stable(i_cell_id))
        else $error("result changed while stalled");

    // A query occupies the sequencer, so no item is taken in the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_QUERY) |=> !i_in_ready)
        else $error("input accepted right after a query");

    // A new result is loaded only while the input side is busy.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while input side was idle");

    // A shown, non-skipped result with a zero id can only be a write echo.
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_skip && (i_cell_id == '0) |-> (i_face_mask == '0))
        else $error("visible faces reported for an empty voxel");

endmodule

bind voxel_face_visibility_unit vfv_checker u_vfv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_face_mask (o_out.face_mask),
    .i_skip      (o_out.skip),
    .i_cell_id   (o_out.cell_id)
);
